### rtl/srsc_pkg.sv
// Shared types and constants for the split-read SV classifier.
package srsc_pkg;

  localparam int PosW    = 31;
  localparam int LenW    = 32;
  localparam int DiffW   = 33;
  localparam int RefW    = 30;
  localparam int WeightW = 24;
  localparam int MinLenW = 20;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;

  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  localparam logic [QCntW-1:0] QFull  = QCntW'(QDepth);
  localparam logic [PosW-1:0]  PosOne = PosW'(1);

  localparam logic [1:0] RegMinSvLen   = 2'd0;
  localparam logic [1:0] RegMinWeight  = 2'd1;
  localparam logic [1:0] RegFallbackEn = 2'd2;

  typedef enum logic [2:0] {
    KindNone = 3'd0,
    KindBnd  = 3'd1,
    KindInv  = 3'd2,
    KindDup  = 3'd3,
    KindDel  = 3'd4,
    KindIns  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [MinLenW-1:0] min_len;
    logic [WeightW-1:0] min_weight;
    logic               fallback_enable;
  } cfg_t;

  typedef struct packed {
    logic               right_side;
    logic [PosW-1:0]    position;
    logic [PosW-1:0]    clip_len;
    logic [WeightW-1:0] weight;
    logic               sa_present;
    logic               same_chrom;
    logic               primary_rev;
    logic               supp_rev;
    logic [PosW-1:0]    supp_pos;
    logic [RefW-1:0]    supp_ref_len;
    logic [RefW-1:0]    supp_query_start;
    logic [RefW-1:0]    supp_query_len;
  } clip_t;

  typedef struct packed {
    kind_e              kind;
    logic               no_sa;
    logic [WeightW-1:0] weight;
    logic [PosW-1:0]    start;
    logic [LenW-1:0]    len;
    logic [LenW-1:0]    mate;
    logic               open;
  } cls_t;

endpackage

### rtl/srsc_cfg.sv
// APB register file holding the classifier thresholds.
module srsc_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srsc_pkg::AddrW-1:0]  paddr,
  input  logic [srsc_pkg::DataW-1:0]  pwdata,
  output logic [srsc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output srsc_pkg::cfg_t              cfg_o
);

  logic [srsc_pkg::MinLenW-1:0] min_len_q;
  logic [srsc_pkg::WeightW-1:0] min_weight_q;
  logic                         fallback_enable_q;
  logic                         wr_en;
  logic [1:0]                   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q         <= srsc_pkg::MinLenW'(50);
      min_weight_q      <= srsc_pkg::WeightW'(2);
      fallback_enable_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        srsc_pkg::RegMinSvLen:   min_len_q         <= pwdata[srsc_pkg::MinLenW-1:0];
        srsc_pkg::RegMinWeight:  min_weight_q      <= pwdata[srsc_pkg::WeightW-1:0];
        srsc_pkg::RegFallbackEn: fallback_enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      srsc_pkg::RegMinSvLen:
        prdata = srsc_pkg::DataW'(min_len_q);
      srsc_pkg::RegMinWeight:
        prdata = srsc_pkg::DataW'(min_weight_q);
      srsc_pkg::RegFallbackEn:
        prdata = srsc_pkg::DataW'(fallback_enable_q);
      default:
        prdata = '0;
    endcase
  end

  assign cfg_o.min_len         = min_len_q;
  assign cfg_o.min_weight      = min_weight_q;
  assign cfg_o.fallback_enable = fallback_enable_q;

endmodule

### rtl/srsc_front.sv
// Front end: accepts clips and classifies them over two register stages.
module srsc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [srsc_pkg::MinLenW-1:0]  min_len_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  srsc_pkg::clip_t               clip_i,
  output logic                          push_o,
  input  logic                          q_ready_i,
  output srsc_pkg::cls_t                cls_o
);

  typedef struct packed {
    logic                         right;
    logic [srsc_pkg::PosW-1:0]    p;
    logic [srsc_pkg::PosW-1:0]    clen;
    logic [srsc_pkg::WeightW-1:0] w;
    logic                         sa;
    logic                         same_chr;
    logic                         strand_match;
    logic [srsc_pkg::PosW-1:0]    spos;
    logic [srsc_pkg::PosW-1:0]    sp0;
    logic [srsc_pkg::LenW-1:0]    spr;
    logic [srsc_pkg::LenW-1:0]    mate_a;
    logic [srsc_pkg::PosW-1:0]    saq;
  } s1_t;

  typedef struct packed {
    logic                         sa;
    logic                         same_chr;
    logic                         strand_match;
    logic [srsc_pkg::WeightW-1:0] w;
    logic [srsc_pkg::PosW-1:0]    p;
    logic [srsc_pkg::DiffW-1:0]   diff;
    logic [srsc_pkg::PosW-1:0]    s;
    logic [srsc_pkg::PosW-1:0]    dq;
    logic [srsc_pkg::PosW-1:0]    inv_lo;
    logic [srsc_pkg::LenW-1:0]    inv_hi;
    logic [srsc_pkg::LenW-1:0]    mate;
    logic                         open;
  } s2_t;

  logic v1_q, v2_q;
  logic ready1, ready2;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;

  logic [srsc_pkg::LenW-1:0]  other;
  logic [srsc_pkg::LenW-1:0]  p_ext;
  logic                       p_lt_other;
  logic [srsc_pkg::PosW-1:0]  dr;
  logic [srsc_pkg::LenW-1:0]  ddq, dqd, min_ext;
  logic [srsc_pkg::DiffW-1:0] neg_diff;
  logic                       del_hit, ins_hit;

  assign ready2     = q_ready_i || !v2_q;
  assign ready1     = ready2 || !v1_q;
  assign in_ready_o = ready1;
  assign push_o     = v2_q;

  always_comb begin
    s1_d.right        = clip_i.right_side;
    s1_d.p            = clip_i.position;
    s1_d.clen         = clip_i.clip_len;
    s1_d.w            = clip_i.weight;
    s1_d.sa           = clip_i.sa_present;
    s1_d.same_chr     = clip_i.same_chrom;
    s1_d.strand_match = clip_i.primary_rev == clip_i.supp_rev;
    s1_d.spos         = clip_i.supp_pos;
    s1_d.sp0          = (clip_i.supp_pos == '0) ? '0 : clip_i.supp_pos - srsc_pkg::PosOne;
    s1_d.spr          = {1'b0, s1_d.sp0} + {2'b00, clip_i.supp_ref_len};
    s1_d.mate_a       = {1'b0, clip_i.supp_pos} + {2'b00, clip_i.supp_ref_len};
    s1_d.saq          = {1'b0, clip_i.supp_query_start} + {1'b0, clip_i.supp_query_len};
  end

  always_comb begin
    p_ext      = {1'b0, s1_q.p};
    other      = s1_q.right ? s1_q.spr : {1'b0, s1_q.sp0};
    p_lt_other = p_ext < other;

    s2_d.sa           = s1_q.sa;
    s2_d.same_chr     = s1_q.same_chr;
    s2_d.strand_match = s1_q.strand_match;
    s2_d.w            = s1_q.w;
    s2_d.p            = s1_q.p;
    s2_d.diff         = s1_q.right ? ({2'b00, s1_q.sp0} - {2'b00, s1_q.p})
                                   : ({2'b00, s1_q.p} - {1'b0, s1_q.spr});
    s2_d.s            = (s1_q.p < s1_q.sp0) ? s1_q.p : s1_q.sp0;
    s2_d.dq           = (s1_q.clen > s1_q.saq) ? s1_q.clen - s1_q.saq : '0;
    s2_d.inv_lo       = p_lt_other ? s1_q.p : other[srsc_pkg::PosW-1:0];
    s2_d.inv_hi       = p_lt_other ? other : p_ext;
    if (s1_q.right) begin
      s2_d.mate = s1_q.strand_match ? {1'b0, s1_q.spos} : s1_q.mate_a;
      s2_d.open = s1_q.strand_match;
    end else begin
      s2_d.mate = s1_q.strand_match ? s1_q.mate_a : {1'b0, s1_q.spos};
      s2_d.open = !s1_q.strand_match;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (ready2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  always_comb begin
    min_ext  = {{(srsc_pkg::LenW-srsc_pkg::MinLenW){1'b0}}, min_len_i};
    dr       = s2_q.diff[srsc_pkg::PosW-1:0];
    ddq      = {1'b0, dr} - {1'b0, s2_q.dq};
    dqd      = {1'b0, s2_q.dq} - {1'b0, dr};
    del_hit  = !ddq[srsc_pkg::LenW-1] && (ddq > min_ext);
    ins_hit  = !dqd[srsc_pkg::LenW-1] && (dqd > min_ext);
    neg_diff = '0 - s2_q.diff;

    cls_o.no_sa  = !s2_q.sa;
    cls_o.weight = s2_q.w;
    cls_o.kind   = srsc_pkg::KindNone;
    cls_o.start  = '0;
    cls_o.len    = '0;
    cls_o.mate   = '0;
    cls_o.open   = 1'b0;
    priority if (!s2_q.sa) begin
      cls_o.kind = srsc_pkg::KindNone;
    end else if (!s2_q.same_chr) begin
      cls_o.kind  = srsc_pkg::KindBnd;
      cls_o.start = s2_q.p;
      cls_o.mate  = s2_q.mate;
      cls_o.open  = s2_q.open;
    end else if (!s2_q.strand_match) begin
      cls_o.kind  = srsc_pkg::KindInv;
      cls_o.start = s2_q.inv_lo;
      cls_o.len   = s2_q.inv_hi - {1'b0, s2_q.inv_lo};
    end else if (s2_q.diff[srsc_pkg::DiffW-1]) begin
      cls_o.kind  = srsc_pkg::KindDup;
      cls_o.start = s2_q.s;
      cls_o.len   = neg_diff[srsc_pkg::LenW-1:0];
    end else if (del_hit) begin
      cls_o.kind  = srsc_pkg::KindDel;
      cls_o.start = s2_q.s;
      cls_o.len   = ddq;
    end else if (ins_hit) begin
      cls_o.kind  = srsc_pkg::KindIns;
      cls_o.start = s2_q.s;
      cls_o.len   = dqd;
    end else begin
      cls_o.kind = srsc_pkg::KindNone;
    end
  end

endmodule

### rtl/srsc_queue.sv
// Four-entry queue of classified words between front and back end.
module srsc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           ready_o,
  input  srsc_pkg::cls_t data_i,
  output logic           valid_o,
  input  logic           pop_i,
  output srsc_pkg::cls_t data_o
);

  srsc_pkg::cls_t                 entry_q [srsc_pkg::QDepth];
  logic [srsc_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [srsc_pkg::QCntW-1:0]     cnt_q;
  logic                           do_push, do_pop;

  assign ready_o = cnt_q != srsc_pkg::QFull;
  assign valid_o = cnt_q != '0;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + srsc_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + srsc_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + srsc_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - srsc_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= srsc_pkg::QFull)
    else $error("queue count above depth");

  a_cnt_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + srsc_pkg::QCntW'(1)))
    else $error("queue count did not advance on push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == cnt_q[srsc_pkg::QPtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

### rtl/srsc_back.sv
// Back end: applies thresholds and holds the result word for the consumer.
module srsc_back #(
  parameter int unsigned POS_WIDTH = 31
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srsc_pkg::cfg_t                  cfg_i,
  input  logic                            q_valid_i,
  output logic                            pop_o,
  input  srsc_pkg::cls_t                  cls_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      sv_kind_o,
  output logic                            emit_o,
  output logic                            consumed_o,
  output logic                            fallback_request_o,
  output logic [srsc_pkg::PosW-1:0]       sv_start_o,
  output logic [srsc_pkg::PosW-1:0]       sv_length_o,
  output logic [srsc_pkg::LenW-1:0]       mate_pos_o,
  output logic                            open_bracket_o
);

  localparam int unsigned MaskW =
    (POS_WIDTH < srsc_pkg::PosW) ? POS_WIDTH : srsc_pkg::PosW;

  logic [srsc_pkg::PosW-1:0] pos_mask;
  logic                      out_valid_q;
  srsc_pkg::kind_e           kind_q;
  logic                      emit_q, emit_d;
  logic                      consumed_q, consumed_d;
  logic                      fb_q;
  logic [srsc_pkg::PosW-1:0] start_q, length_q;
  logic [srsc_pkg::LenW-1:0] mate_q;
  logic                      open_q;
  logic                      wok, len_ok;

  always_comb begin
    for (int i = 0; i < srsc_pkg::PosW; i++) begin
      pos_mask[i] = (i < MaskW);
    end
  end

  assign pop_o  = q_valid_i && (!out_valid_q || out_ready_i);
  assign wok    = cls_i.weight >= cfg_i.min_weight;
  assign len_ok = cls_i.len >=
                  {{(srsc_pkg::LenW-srsc_pkg::MinLenW){1'b0}}, cfg_i.min_len};

  always_comb begin
    unique case (cls_i.kind)
      srsc_pkg::KindNone: begin
        emit_d     = 1'b0;
        consumed_d = 1'b0;
      end
      srsc_pkg::KindBnd: begin
        emit_d     = wok;
        consumed_d = 1'b1;
      end
      srsc_pkg::KindInv: begin
        emit_d     = len_ok && wok;
        consumed_d = 1'b1;
      end
      srsc_pkg::KindDup, srsc_pkg::KindDel, srsc_pkg::KindIns: begin
        emit_d     = len_ok && wok;
        consumed_d = len_ok && wok;
      end
      default: begin
        emit_d     = 1'b0;
        consumed_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q     <= cls_i.kind;
      emit_q     <= emit_d;
      consumed_q <= consumed_d;
      fb_q       <= cls_i.no_sa && cfg_i.fallback_enable;
      start_q    <= cls_i.start & pos_mask;
      length_q   <= cls_i.len[srsc_pkg::PosW-1:0] & pos_mask;
      mate_q     <= cls_i.mate;
      open_q     <= cls_i.open;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sv_kind_o          = kind_q;
  assign emit_o             = emit_q;
  assign consumed_o         = consumed_q;
  assign fallback_request_o = fb_q;
  assign sv_start_o         = start_q;
  assign sv_length_o        = length_q;
  assign mate_pos_o         = mate_q;
  assign open_bracket_o     = open_q;

  a_none_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == srsc_pkg::KindNone) |-> (!emit_q && !consumed_q))
    else $error("no-call word marked emitted or consumed");

  a_fb_no_call: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && fb_q) |-> (kind_q == srsc_pkg::KindNone))
    else $error("fallback requested alongside a call");

  a_emit_consumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && emit_q) |-> consumed_q)
    else $error("emitted call not consumed");

endmodule

### rtl/split_read_sv_classify.sv
// Top level of the split-read structural-variant classifier.
// Each accepted clip word yields exactly one result word. The block takes one
// word per clock cycle while in_ready_o is high; a result passes through the
// two register stages in the classifier, the four-entry queue and the output
// register before it reaches the output.
// The queue lets the classifier keep accepting while the consumer holds off;
// the block takes up to seven words in all (output register, four queue
// entries and both classifier stages) before it stalls its input. Thresholds
// are written through the APB port at byte addresses 0 (minimum length),
// 4 (min_weight) and 8 (fallback_enable); there is no clearing pass after
// reset. POS_WIDTH masks sv_start and sv_length.
module split_read_sv_classify #(
  parameter int unsigned POS_WIDTH = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srsc_pkg::AddrW-1:0]  paddr,
  input  logic [srsc_pkg::DataW-1:0]  pwdata,
  output logic [srsc_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        right_side_i,
  input  logic [srsc_pkg::PosW-1:0]   position_i,
  input  logic [srsc_pkg::PosW-1:0]   clip_len_i,
  input  logic [srsc_pkg::WeightW-1:0] weight_i,
  input  logic                        sa_present_i,
  input  logic                        same_chrom_i,
  input  logic                        primary_rev_i,
  input  logic                        supp_rev_i,
  input  logic [srsc_pkg::PosW-1:0]   supp_pos_i,
  input  logic [srsc_pkg::RefW-1:0]   supp_ref_len_i,
  input  logic [srsc_pkg::RefW-1:0]   supp_query_start_i,
  input  logic [srsc_pkg::RefW-1:0]   supp_query_len_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  sv_kind_o,
  output logic                        emit_o,
  output logic                        consumed_o,
  output logic                        fallback_request_o,
  output logic [srsc_pkg::PosW-1:0]   sv_start_o,
  output logic [srsc_pkg::PosW-1:0]   sv_length_o,
  output logic [srsc_pkg::LenW-1:0]   mate_pos_o,
  output logic                        open_bracket_o
);

  srsc_pkg::cfg_t  cfg;
  srsc_pkg::clip_t clip;
  srsc_pkg::cls_t  cls_push, cls_pop;
  logic            push, q_ready, q_valid, pop;

  assign clip.right_side       = right_side_i;
  assign clip.position         = position_i;
  assign clip.clip_len         = clip_len_i;
  assign clip.weight           = weight_i;
  assign clip.sa_present       = sa_present_i;
  assign clip.same_chrom       = same_chrom_i;
  assign clip.primary_rev      = primary_rev_i;
  assign clip.supp_rev         = supp_rev_i;
  assign clip.supp_pos         = supp_pos_i;
  assign clip.supp_ref_len     = supp_ref_len_i;
  assign clip.supp_query_start = supp_query_start_i;
  assign clip.supp_query_len   = supp_query_len_i;

  srsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_len_i    (cfg.min_len),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .clip_i       (clip),
    .push_o       (push),
    .q_ready_i    (q_ready),
    .cls_o        (cls_push)
  );

  srsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .data_i  (cls_push),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (cls_pop)
  );

  srsc_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .q_valid_i          (q_valid),
    .pop_o              (pop),
    .cls_i              (cls_pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sv_kind_o          (sv_kind_o),
    .emit_o             (emit_o),
    .consumed_o         (consumed_o),
    .fallback_request_o (fallback_request_o),
    .sv_start_o         (sv_start_o),
    .sv_length_o        (sv_length_o),
    .mate_pos_o         (mate_pos_o),
    .open_bracket_o     (open_bracket_o)
  );

endmodule

### tb/tb.sv
// Testbench for split_read_sv_classify: checks each call word against a built-in classifier.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    srsc_pkg::kind_e                kind;
    logic                           emit;
    logic                           consumed;
    logic                           fallback;
    logic [srsc_pkg::PosW-1:0]      start;
    logic [srsc_pkg::PosW-1:0]      length;
    logic [srsc_pkg::LenW-1:0]      mate;
    logic                           open;
  } sv_call_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [srsc_pkg::AddrW-1:0]     paddr;
  logic [srsc_pkg::DataW-1:0]     pwdata;
  logic [srsc_pkg::DataW-1:0]     prdata;
  logic                           pready;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           right_side_i;
  logic [srsc_pkg::PosW-1:0]      position_i;
  logic [srsc_pkg::PosW-1:0]      clip_len_i;
  logic [srsc_pkg::WeightW-1:0]   weight_i;
  logic                           sa_present_i;
  logic                           same_chrom_i;
  logic                           primary_rev_i;
  logic                           supp_rev_i;
  logic [srsc_pkg::PosW-1:0]      supp_pos_i;
  logic [srsc_pkg::RefW-1:0]      supp_ref_len_i;
  logic [srsc_pkg::RefW-1:0]      supp_query_start_i;
  logic [srsc_pkg::RefW-1:0]      supp_query_len_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [2:0]                     sv_kind_o;
  logic                           emit_o;
  logic                           consumed_o;
  logic                           fallback_request_o;
  logic [srsc_pkg::PosW-1:0]      sv_start_o;
  logic [srsc_pkg::PosW-1:0]      sv_length_o;
  logic [srsc_pkg::LenW-1:0]      mate_pos_o;
  logic                           open_bracket_o;

  srsc_pkg::cfg_t thresholds;
  sv_call_t       pending_calls[$];
  int             fail_count;
  int             clips_sent;
  int             calls_checked;
  int             settings_count;
  int             emitted_count;
  int             fallback_count;
  int             kind_count[6];
  bit             tx_idle_en;
  bit             rx_idle_en;
  bit             hold_req;

  split_read_sv_classify i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .right_side_i       (right_side_i),
    .position_i         (position_i),
    .clip_len_i         (clip_len_i),
    .weight_i           (weight_i),
    .sa_present_i       (sa_present_i),
    .same_chrom_i       (same_chrom_i),
    .primary_rev_i      (primary_rev_i),
    .supp_rev_i         (supp_rev_i),
    .supp_pos_i         (supp_pos_i),
    .supp_ref_len_i     (supp_ref_len_i),
    .supp_query_start_i (supp_query_start_i),
    .supp_query_len_i   (supp_query_len_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .sv_kind_o          (sv_kind_o),
    .emit_o             (emit_o),
    .consumed_o         (consumed_o),
    .fallback_request_o (fallback_request_o),
    .sv_start_o         (sv_start_o),
    .sv_length_o        (sv_length_o),
    .mate_pos_o         (mate_pos_o),
    .open_bracket_o     (open_bracket_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic sv_call_t classify_clip(srsc_pkg::clip_t c, srsc_pkg::cfg_t t);
    sv_call_t r;
    longint p, spos, sp0, sref, saq, clen, ml, w, mw, other, lo, hi, diff, dq, len;
    bit strand_match;
    r = '0;
    r.kind = srsc_pkg::KindNone;
    p = c.position;
    spos = c.supp_pos;
    sref = c.supp_ref_len;
    saq = longint'(c.supp_query_start) + longint'(c.supp_query_len);
    clen = c.clip_len;
    ml = t.min_len;
    w = c.weight;
    mw = t.min_weight;
    len = 0;
    if (!c.sa_present) begin
      r.fallback = t.fallback_enable;
    end else begin
      sp0 = (spos > 0) ? spos - 1 : 0;
      strand_match = (c.primary_rev == c.supp_rev);
      if (!c.same_chrom) begin
        r.kind = srsc_pkg::KindBnd;
        r.consumed = 1'b1;
        r.emit = (w >= mw);
        r.start = c.position;
        r.open = (c.right_side == strand_match);
        r.mate = r.open ? srsc_pkg::LenW'(spos) : srsc_pkg::LenW'(spos + sref);
      end else if (!strand_match) begin
        other = c.right_side ? sp0 + sref : sp0;
        lo = (p < other) ? p : other;
        hi = (p < other) ? other : p;
        len = hi - lo;
        r.kind = srsc_pkg::KindInv;
        r.consumed = 1'b1;
        r.start = srsc_pkg::PosW'(lo);
        r.length = srsc_pkg::PosW'(len);
        r.emit = (len >= ml) && (w >= mw);
      end else begin
        diff = c.right_side ? sp0 - p : p - (sp0 + sref);
        lo = (p < sp0) ? p : sp0;
        if (diff < 0) begin
          r.kind = srsc_pkg::KindDup;
          len = -diff;
        end else begin
          dq = (clen > saq) ? clen - saq : 0;
          if (diff > dq + ml) begin
            r.kind = srsc_pkg::KindDel;
            len = diff - dq;
          end else if (dq > diff + ml) begin
            r.kind = srsc_pkg::KindIns;
            len = dq - diff;
          end
        end
        if (r.kind != srsc_pkg::KindNone) begin
          r.start = srsc_pkg::PosW'(lo);
          r.length = srsc_pkg::PosW'(len);
          r.emit = (len >= ml) && (w >= mw);
          r.consumed = r.emit;
        end
      end
    end
    return r;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  function automatic logic [srsc_pkg::PosW-1:0] clamp_pos(longint v);
    if (v < 0) return '0;
    if (v > 64'h7FFF_FFFF) return '1;
    return srsc_pkg::PosW'(v);
  endfunction

  function automatic srsc_pkg::clip_t base_clip();
    srsc_pkg::clip_t c;
    c.right_side = 1'b0;
    c.position = srsc_pkg::PosW'(10000);
    c.clip_len = srsc_pkg::PosW'(100);
    c.weight = srsc_pkg::WeightW'(10);
    c.sa_present = 1'b1;
    c.same_chrom = 1'b1;
    c.primary_rev = 1'b0;
    c.supp_rev = 1'b0;
    c.supp_pos = srsc_pkg::PosW'(9601);
    c.supp_ref_len = srsc_pkg::RefW'(100);
    c.supp_query_start = '0;
    c.supp_query_len = srsc_pkg::RefW'(100);
    return c;
  endfunction

  function automatic srsc_pkg::clip_t random_clip();
    srsc_pkg::clip_t c;
    longint span, p, d, sp0, sref, saq;
    if ($urandom_range(0, 7) == 0) begin
      c.right_side = 1'($urandom);
      c.position = srsc_pkg::PosW'($urandom);
      c.clip_len = srsc_pkg::PosW'($urandom);
      c.weight = srsc_pkg::WeightW'($urandom);
      c.sa_present = 1'($urandom);
      c.same_chrom = 1'($urandom);
      c.primary_rev = 1'($urandom);
      c.supp_rev = 1'($urandom);
      c.supp_pos = srsc_pkg::PosW'($urandom);
      c.supp_ref_len = srsc_pkg::RefW'($urandom);
      c.supp_query_start = srsc_pkg::RefW'($urandom);
      c.supp_query_len = srsc_pkg::RefW'($urandom);
      return c;
    end
    span = longint'(thresholds.min_len) + 8;
    c.right_side = 1'($urandom);
    c.sa_present = ($urandom_range(0, 9) != 0);
    c.same_chrom = ($urandom_range(0, 4) != 0);
    c.primary_rev = 1'($urandom);
    c.supp_rev = ($urandom_range(0, 2) == 0) ? ~c.primary_rev : c.primary_rev;
    case ($urandom_range(0, 3))
      0: c.weight = srsc_pkg::WeightW'($urandom);
      1: c.weight = srsc_pkg::WeightW'(clamp_pos(longint'(thresholds.min_weight) +
                                                 longint'($urandom_range(0, 2)) - 1));
      default: c.weight = srsc_pkg::WeightW'($urandom_range(0, 20));
    endcase
    p = $urandom_range(0, 2000000);
    sref = $urandom_range(0, 3000);
    d = longint'($urandom_range(0, 32'(3 * span))) - span;
    sp0 = c.right_side ? p + d : p - d - sref;
    c.position = clamp_pos(p);
    c.supp_ref_len = srsc_pkg::RefW'(sref);
    c.supp_pos = (sp0 < 0) ? '0 : clamp_pos(sp0 + 1);
    c.supp_query_start = srsc_pkg::RefW'($urandom_range(0, 500));
    c.supp_query_len = srsc_pkg::RefW'($urandom_range(0, 500));
    saq = longint'(c.supp_query_start) + longint'(c.supp_query_len);
    c.clip_len = clamp_pos(saq + longint'($urandom_range(0, 32'(3 * span))) - span);
    return c;
  endfunction

  task automatic drive_clip(input srsc_pkg::clip_t c);
    right_side_i = c.right_side;
    position_i = c.position;
    clip_len_i = c.clip_len;
    weight_i = c.weight;
    sa_present_i = c.sa_present;
    same_chrom_i = c.same_chrom;
    primary_rev_i = c.primary_rev;
    supp_rev_i = c.supp_rev;
    supp_pos_i = c.supp_pos;
    supp_ref_len_i = c.supp_ref_len;
    supp_query_start_i = c.supp_query_start;
    supp_query_len_i = c.supp_query_len;
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_clip(input srsc_pkg::clip_t c);
    sv_call_t want;
    drive_clip(c);
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = classify_clip(c, thresholds);
    pending_calls = {pending_calls, want};
    clips_sent++;
    kind_count[int'(want.kind)]++;
    emitted_count += want.emit;
    fallback_count += want.fallback;
    @(negedge clk_i);
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      in_valid_i = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
  endtask

  task automatic drain_calls();
    in_valid_i = 1'b0;
    while (pending_calls.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [srsc_pkg::DataW-1:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = srsc_pkg::AddrW'({idx, 2'b00});
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      srsc_pkg::RegMinSvLen:   thresholds.min_len = value[srsc_pkg::MinLenW-1:0];
      srsc_pkg::RegMinWeight:  thresholds.min_weight = value[srsc_pkg::WeightW-1:0];
      srsc_pkg::RegFallbackEn: thresholds.fallback_enable = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_thresholds(input logic [srsc_pkg::DataW-1:0] min_len,
                                input logic [srsc_pkg::DataW-1:0] min_wt,
                                input logic [srsc_pkg::DataW-1:0] fb_en);
    drain_calls();
    write_reg(srsc_pkg::RegMinSvLen, min_len);
    write_reg(srsc_pkg::RegMinWeight, min_wt);
    write_reg(srsc_pkg::RegFallbackEn, fb_en);
    settings_count++;
  endtask

  task automatic test_directed_kinds();
    srsc_pkg::clip_t c;
    send_clip(base_clip());
    c = base_clip();
    c.sa_present = 1'b0;
    send_clip(c);
    for (int k = 0; k < 4; k++) begin
      c = base_clip();
      c.same_chrom = 1'b0;
      c.right_side = k[0];
      c.supp_rev = k[1];
      send_clip(c);
    end
    c = base_clip();
    c.supp_rev = 1'b1;
    send_clip(c);
    c.right_side = 1'b1;
    send_clip(c);
    c = base_clip();
    c.right_side = 1'b1;
    c.supp_pos = srsc_pkg::PosW'(9801);
    send_clip(c);
    c = base_clip();
    c.supp_pos = srsc_pkg::PosW'(9801);
    c.clip_len = srsc_pkg::PosW'(500);
    send_clip(c);
    c = base_clip();
    c.supp_pos = srsc_pkg::PosW'(9871);
    send_clip(c);
    c = base_clip();
    c.weight = srsc_pkg::WeightW'(1);
    send_clip(c);
    c = base_clip();
    c.right_side = 1'b1;
    c.supp_pos = '0;
    send_clip(c);
    c = base_clip();
    c.supp_query_len = '0;
    send_clip(c);
    send_clip('1);
    send_clip('0);
  endtask

  task automatic test_threshold_extremes();
    srsc_pkg::clip_t c;
    set_thresholds(32'd0, 32'd0, 32'd1);
    send_clip('1);
    c = base_clip();
    c.sa_present = 1'b0;
    send_clip(c);
    c = base_clip();
    c.supp_pos = srsc_pkg::PosW'(9901);
    send_clip(c);
    c = base_clip();
    c.supp_rev = 1'b1;
    c.supp_pos = srsc_pkg::PosW'(10001);
    send_clip(c);
    set_thresholds('1, '1, '1);
    c = base_clip();
    c.position = '1;
    c.supp_pos = srsc_pkg::PosW'(1);
    c.supp_ref_len = '0;
    c.clip_len = '0;
    c.weight = '1;
    send_clip(c);
    c.sa_present = 1'b0;
    send_clip(c);
    c = base_clip();
    c.right_side = 1'b1;
    c.position = '0;
    c.supp_pos = '1;
    c.supp_ref_len = '1;
    c.supp_rev = 1'b1;
    send_clip(c);
    c.same_chrom = 1'b0;
    send_clip(c);
  endtask

  task automatic test_random_sweep();
    logic [srsc_pkg::MinLenW-1:0]  min_len;
    logic [srsc_pkg::WeightW-1:0]  min_wt;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          min_len = '0;
          min_wt = '0;
        end
        1: begin
          min_len = '1;
          min_wt = '1;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: min_len = srsc_pkg::MinLenW'($urandom_range(0, 4));
            1: min_len = srsc_pkg::MinLenW'(50);
            default: min_len = srsc_pkg::MinLenW'($urandom_range(0, 400));
          endcase
          min_wt = srsc_pkg::WeightW'($urandom_range(0, 8));
        end
      endcase
      set_thresholds({12'($urandom), min_len}, {8'($urandom), min_wt},
                     {31'($urandom), phase[0]});
      // one phase runs with both sides streaming flat out
      tx_idle_en = (phase != 3);
      rx_idle_en = (phase != 3);
      repeat (90) send_clip(random_clip());
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_hold_off();
    drain_calls();
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (24) send_clip(random_clip());
    tx_idle_en = 1'b1;
    drain_calls();
  endtask

  task automatic test_drain_pause();
    repeat (3) begin
      repeat (15) send_clip(random_clip());
      drain_calls();
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i = 1'b0;
        repeat (gap_len() - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_calls
    sv_call_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = srsc_pkg::kind_e'(sv_kind_o);
      got.emit = emit_o;
      got.consumed = consumed_o;
      got.fallback = fallback_request_o;
      got.start = sv_start_o;
      got.length = sv_length_o;
      got.mate = mate_pos_o;
      got.open = open_bracket_o;
      if (pending_calls.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: call word with none pending: kind %0d start %0d len %0d",
                   sv_kind_o, sv_start_o, sv_length_o);
      end else begin
        want = pending_calls.pop_front();
        if (got.kind !== want.kind || got.emit !== want.emit ||
            got.consumed !== want.consumed || got.fallback !== want.fallback ||
            got.start !== want.start || got.length !== want.length ||
            got.mate !== want.mate || got.open !== want.open) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("ERROR: call %0d expected kind %0d emit %0b cons %0b fb %0b",
                     calls_checked, want.kind, want.emit, want.consumed, want.fallback,
                     " start %0d len %0d mate %0d open %0b", want.start, want.length,
                     want.mate, want.open);
            $display("       got      kind %0d emit %0b cons %0b fb %0b",
                     got.kind, got.emit, got.consumed, got.fallback,
                     " start %0d len %0d mate %0d open %0b", got.start, got.length,
                     got.mate, got.open);
          end
        end
        calls_checked++;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no word moved for %0d cycles", QuietLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    drive_clip('0);
    thresholds.min_len = srsc_pkg::MinLenW'(50);
    thresholds.min_weight = srsc_pkg::WeightW'(2);
    thresholds.fallback_enable = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_kinds();
    test_threshold_extremes();
    test_random_sweep();
    test_output_hold_off();
    test_drain_pause();

    drain_calls();
    repeat (8) @(posedge clk_i);
    if (pending_calls.size() != 0) begin
      fail_count++;
      $display("ERROR: %0d call words never arrived", pending_calls.size());
    end
    if (fail_count > 10) $display("%0d failures in total", fail_count);
    $display("Classified %0d clips under %0d threshold settings, one %0d-cycle hold-off",
             clips_sent, settings_count, HoldCycles);
    $display("Calls: none %0d bnd %0d inv %0d dup %0d del %0d ins %0d, emit %0d, fb %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4],
             kind_count[5], emitted_count, fallback_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
